// File: src/wstd_pkg.sv
`default_nettype none

package wstd_pkg;

    // Default sizing of the dispatcher
    localparam int WORKER_CNT_DEF  = 8;
    localparam int DEQUE_DEPTH_DEF = 256;

    // Active worker count after reset
    localparam logic [3:0] ACTIVE_RESET = 4'd8;

    // Item kinds
    localparam logic KIND_SUBMIT = 1'b0;
    localparam logic KIND_FETCH  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Request item
    typedef struct packed {
        logic        kind;
        logic [2:0]  requester;
        logic [31:0] task_handle;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_handle;
        logic [31:0] sequence_number;
        logic [2:0]  chosen_worker;
        logic        was_stolen;
    } t_out_item;

endpackage

`default_nettype wire

// File: src/wstd_ptr_table.sv
`default_nettype none

// Head/tail pointer table, one entry per worker, one read and one write port.
// Entries never written since reset read as zero.
module wstd_ptr_table #(
    parameter int WORKER_CNT  = wstd_pkg::WORKER_CNT_DEF,
    parameter int DEQUE_DEPTH = wstd_pkg::DEQUE_DEPTH_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire  [$clog2(WORKER_CNT)-1:0]         i_rd_addr,
    output logic [$clog2(DEQUE_DEPTH):0]          o_rd_head,
    output logic [$clog2(DEQUE_DEPTH):0]          o_rd_tail,
    input  wire                                   i_we,
    input  wire  [$clog2(WORKER_CNT)-1:0]         i_wr_addr,
    input  wire  [$clog2(DEQUE_DEPTH):0]          i_wr_head,
    input  wire  [$clog2(DEQUE_DEPTH):0]          i_wr_tail
);
    import wstd_pkg::*;

    localparam int PW = $clog2(DEQUE_DEPTH) + 1;

    logic [2*PW-1:0]      r_mem [WORKER_CNT];
    logic [WORKER_CNT-1:0] r_vld;
    logic                 r_rd_vld;
    logic [2*PW-1:0]      r_rd_data;

    // Valid bits and registered read valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[i_rd_addr];
            if (i_we) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
        end
    end

    // Pointer storage
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= {i_wr_head, i_wr_tail};
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_head = r_rd_vld ? r_rd_data[2*PW-1:PW] : '0;
    assign o_rd_tail = r_rd_vld ? r_rd_data[PW-1:0]    : '0;

endmodule

`default_nettype wire

// File: src/wstd_task_ram.sv
`default_nettype none

// Task handle store: worker index in the upper address bits, slot below.
module wstd_task_ram #(
    parameter int WORKER_CNT  = wstd_pkg::WORKER_CNT_DEF,
    parameter int DEQUE_DEPTH = wstd_pkg::DEQUE_DEPTH_DEF
) (
    input  wire                                               i_clk,
    input  wire                                               i_we,
    input  wire  [$clog2(WORKER_CNT)+$clog2(DEQUE_DEPTH)-1:0] i_wr_addr,
    input  wire  [31:0]                                       i_wr_data,
    input  wire                                               i_rd_en,
    input  wire  [$clog2(WORKER_CNT)+$clog2(DEQUE_DEPTH)-1:0] i_rd_addr,
    output logic [31:0]                                       o_rd_data
);
    import wstd_pkg::*;

    localparam int RAW   = $clog2(WORKER_CNT) + $clog2(DEQUE_DEPTH);
    localparam int DEPTH = 1 << RAW;

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: src/wstd_seq.sv
`default_nettype none

// Dispatch sequencer: checks a fetch's own deque first, else walks the pointer table
// one worker per cycle through a shared load/compare unit, then updates pointers and writes or reads the task store.
module wstd_seq #(
    parameter int WORKER_CNT  = wstd_pkg::WORKER_CNT_DEF,
    parameter int DEQUE_DEPTH = wstd_pkg::DEQUE_DEPTH_DEF
) (
    input  wire                                               i_clk,
    input  wire                                               i_rst_n,
    input  wire  [$clog2(WORKER_CNT+1)-1:0]                   i_act,
    input  wire                                               i_in_valid,
    output logic                                              o_in_stall,
    input  wire  wstd_pkg::t_in_item                          i_in_item,
    output logic                                              o_res_vld,
    input  wire                                               i_res_take,
    output wstd_pkg::t_out_item                               o_res,
    output logic [$clog2(WORKER_CNT)-1:0]                     o_ptr_rd_addr,
    input  wire  [$clog2(DEQUE_DEPTH):0]                      i_ptr_rd_head,
    input  wire  [$clog2(DEQUE_DEPTH):0]                      i_ptr_rd_tail,
    output logic                                              o_ptr_we,
    output logic [$clog2(WORKER_CNT)-1:0]                     o_ptr_wr_addr,
    output logic [$clog2(DEQUE_DEPTH):0]                      o_ptr_wr_head,
    output logic [$clog2(DEQUE_DEPTH):0]                      o_ptr_wr_tail,
    output logic                                              o_ram_we,
    output logic [$clog2(WORKER_CNT)+$clog2(DEQUE_DEPTH)-1:0] o_ram_wr_addr,
    output logic [31:0]                                       o_ram_wr_data,
    output logic                                              o_ram_rd_en,
    output logic [$clog2(WORKER_CNT)+$clog2(DEQUE_DEPTH)-1:0] o_ram_rd_addr,
    input  wire  [31:0]                                       i_ram_rd_data
);
    import wstd_pkg::*;

    localparam int WW = $clog2(WORKER_CNT);
    localparam int AW = $clog2(WORKER_CNT + 1);
    localparam int DW = $clog2(DEQUE_DEPTH);
    localparam int PW = DW + 1;
    localparam logic [PW:0] SPAN_X  = (PW+1)'(2 * DEQUE_DEPTH);
    localparam logic [PW:0] DEPTH_X = (PW+1)'(DEQUE_DEPTH);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_OWN_CHK = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_APPLY   = 3'd3;
    localparam logic [2:0] S_WAIT    = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    // Pointer arithmetic, indexes run modulo twice the depth
    function automatic logic [PW-1:0] f_load(input logic [PW-1:0] h, input logic [PW-1:0] t);
        logic [PW:0] d;
        d = {1'b0, t} - {1'b0, h};
        if (d[PW]) begin
            d = d + SPAN_X;
        end
        return d[PW-1:0];
    endfunction

    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] x);
        logic [PW:0] n;
        n = {1'b0, x} + (PW+1)'(1);
        if (n == SPAN_X) begin
            n = '0;
        end
        return n[PW-1:0];
    endfunction

    function automatic logic [PW-1:0] f_dec(input logic [PW-1:0] x);
        logic [PW:0] n;
        if (x == '0) begin
            n = SPAN_X - (PW+1)'(1);
        end else begin
            n = {1'b0, x} - (PW+1)'(1);
        end
        return n[PW-1:0];
    endfunction

    function automatic logic [DW-1:0] f_slot(input logic [PW-1:0] x);
        logic [PW:0] n;
        n = {1'b0, x};
        if (n >= DEPTH_X) begin
            n = n - DEPTH_X;
        end
        return n[DW-1:0];
    endfunction

    logic [2:0]      r_state, n_state;
    logic            r_kind, n_kind;
    logic [2:0]      r_req, n_req;
    logic [31:0]     r_handle, n_handle;
    logic [31:0]     r_seq, n_seq;
    logic [AW-1:0]   r_idx, n_idx;
    logic            r_chk_vld, n_chk_vld;
    logic [WW-1:0]   r_chk_idx, n_chk_idx;
    logic            r_found, n_found;
    logic [PW-1:0]   r_min, n_min;
    logic [WW-1:0]   r_best, n_best;
    logic [PW-1:0]   r_bhead, n_bhead;
    logic [PW-1:0]   r_btail, n_btail;
    t_out_item       r_res, n_res;

    logic            accept;
    logic            issuing;
    logic [PW-1:0]   cur_load;
    logic [WW-1:0]   own_idx;
    logic [PW-1:0]   steal_tail;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign issuing    = (r_state == S_SCAN) && (r_idx < i_act) && !r_found;
    assign cur_load   = f_load(i_ptr_rd_head, i_ptr_rd_tail);
    assign own_idx    = WW'(r_req);
    assign steal_tail = f_dec(r_btail);

    // Pointer read address: requester at accept, scan index while scanning, own deque otherwise
    always_comb begin
        if (r_state == S_IDLE) begin
            o_ptr_rd_addr = WW'(i_in_item.requester);
        end else if (r_state == S_SCAN) begin
            o_ptr_rd_addr = r_idx[WW-1:0];
        end else begin
            o_ptr_rd_addr = own_idx;
        end
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_req     = r_req;
        n_handle  = r_handle;
        n_seq     = r_seq;
        n_idx     = r_idx;
        n_chk_vld = r_chk_vld;
        n_chk_idx = r_chk_idx;
        n_found   = r_found;
        n_min     = r_min;
        n_best    = r_best;
        n_bhead   = r_bhead;
        n_btail   = r_btail;
        n_res     = r_res;

        o_ptr_we      = 1'b0;
        o_ptr_wr_addr = r_best;
        o_ptr_wr_head = r_bhead;
        o_ptr_wr_tail = r_btail;
        o_ram_we      = 1'b0;
        o_ram_wr_addr = {r_best, f_slot(r_btail)};
        o_ram_wr_data = r_handle;
        o_ram_rd_en   = 1'b0;
        o_ram_rd_addr = {r_best, f_slot(steal_tail)};

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_kind        = i_in_item.kind;
                    n_req         = i_in_item.requester;
                    n_handle      = i_in_item.task_handle;
                    n_idx         = '0;
                    n_chk_vld     = 1'b0;
                    n_found       = 1'b0;
                    n_res         = '0;
                    n_res.status  = ST_EMPTY;
                    if (i_in_item.kind == KIND_SUBMIT) begin
                        n_seq                 = r_seq + 32'd1;
                        n_res.sequence_number = r_seq + 32'd1;
                        n_state               = S_SCAN;
                    end else if (32'(i_in_item.requester) < 32'(WORKER_CNT)) begin
                        n_state = S_OWN_CHK;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            // Pop the head of the requester's own deque if it holds anything
            S_OWN_CHK: begin
                if (cur_load != '0) begin
                    o_ptr_we            = 1'b1;
                    o_ptr_wr_addr       = own_idx;
                    o_ptr_wr_head       = f_inc(i_ptr_rd_head);
                    o_ptr_wr_tail       = i_ptr_rd_tail;
                    o_ram_rd_en         = 1'b1;
                    o_ram_rd_addr       = {own_idx, f_slot(i_ptr_rd_head)};
                    n_res.status        = ST_OK;
                    n_res.chosen_worker = 3'(own_idx);
                    n_state             = S_WAIT;
                end else begin
                    n_state = S_SCAN;
                end
            end

            // One worker per cycle: least load for submit, first victim for fetch
            S_SCAN: begin
                n_chk_vld = issuing;
                n_chk_idx = r_idx[WW-1:0];
                if (issuing) begin
                    n_idx = r_idx + AW'(1);
                end
                if (r_chk_vld) begin
                    if (r_kind == KIND_SUBMIT) begin
                        if (r_chk_idx == '0 || cur_load < r_min) begin
                            n_min   = cur_load;
                            n_best  = r_chk_idx;
                            n_bhead = i_ptr_rd_head;
                            n_btail = i_ptr_rd_tail;
                        end
                    end else if (!r_found && (32'(r_chk_idx) != 32'(r_req))
                                 && cur_load != '0) begin
                        n_found = 1'b1;
                        n_best  = r_chk_idx;
                        n_bhead = i_ptr_rd_head;
                        n_btail = i_ptr_rd_tail;
                    end
                end
                if (r_found || (!issuing && !r_chk_vld)) begin
                    n_state = S_APPLY;
                end
            end

            S_APPLY: begin
                if (r_kind == KIND_SUBMIT) begin
                    n_res.chosen_worker = 3'(r_best);
                    n_state             = S_DONE;
                    if ({1'b0, r_min} >= DEPTH_X) begin
                        n_res.status = ST_FULL;
                    end else begin
                        o_ram_we      = 1'b1;
                        o_ptr_we      = 1'b1;
                        o_ptr_wr_tail = f_inc(r_btail);
                        n_res.status  = ST_OK;
                    end
                end else if (r_found) begin
                    // Steal from the victim's tail
                    o_ptr_we            = 1'b1;
                    o_ptr_wr_tail       = steal_tail;
                    o_ram_rd_en         = 1'b1;
                    n_res.status        = ST_OK;
                    n_res.chosen_worker = 3'(r_best);
                    n_res.was_stolen    = 1'b1;
                    n_state             = S_WAIT;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_WAIT: begin
                n_res.out_handle = i_ram_rd_data;
                n_state          = S_DONE;
            end

            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_seq     <= '0;
            r_chk_vld <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_seq     <= n_seq;
            r_chk_vld <= n_chk_vld;
            r_found   <= n_found;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_req     <= n_req;
        r_handle  <= n_handle;
        r_idx     <= n_idx;
        r_chk_idx <= n_chk_idx;
        r_min     <= n_min;
        r_best    <= n_best;
        r_bhead   <= n_bhead;
        r_btail   <= n_btail;
        r_res     <= n_res;
    end

    assign o_res_vld = (r_state == S_DONE);
    assign o_res     = r_res;

`ifndef SYNTH
    // An accepted item keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_in_stall)
        else $error("accepted item did not make the dispatcher busy");

    // A rejected submit touches neither pointers nor the task store
    a_full_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY && r_kind == KIND_SUBMIT && {1'b0, r_min} >= DEPTH_X)
        |-> (!o_ptr_we && !o_ram_we))
        else $error("full submit wrote state");

    // A steal never names the requester itself
    a_steal_other: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_vld && r_res.was_stolen) |-> (32'(r_best) != 32'(r_req)))
        else $error("steal took from the requester's own deque");

    // Scan index stays within the active worker count
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= i_act))
        else $error("scan index ran past the active count");

    // Sequence counter steps by one on each submit
    a_seq_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_item.kind == KIND_SUBMIT) |=> (r_seq == $past(r_seq) + 32'd1))
        else $error("sequence counter did not advance on submit");
`endif

endmodule

`default_nettype wire

// File: src/work_stealing_task_dispatcher.sv
// Work-stealing task dispatcher: one circular task deque per worker.
// Request channel: i_in_valid / o_in_stall / i_in_item. kind 0 submits
// task_handle to the least-loaded active worker (lowest index on ties);
// kind 1 fetches for requester: head of its own deque, else the tail of the
// first other non-empty active worker, else status empty.
// Result channel: o_out_valid / i_out_stall / o_out_item, one result per item.
// Config: i_cfg_we / i_cfg_wdata set the active worker count; the user must
// write it only while idle, as the block itself does not enforce this.
// One item at a time. The pointer table is walked one worker per cycle through
// its single registered read port. A fetch served from its own deque skips the
// walk; a submit or an empty fetch walks every active worker, and a steal
// stops the walk at its victim.
// The sequencer returns to idle at the same edge that latches the result, and
// the output register frees it as soon as that result is latched, so the next
// item is taken while that result waits on a stalled receiver; the sequencer
// only holds a finished result while the output register is full and stalled.
// Reset (synchronous, active low) empties all deques, clears the sequence
// counter and sets the active count to 8. No clearing pass is needed.
`default_nettype none

module work_stealing_task_dispatcher #(
    parameter int WORKER_CNT  = wstd_pkg::WORKER_CNT_DEF,
    parameter int DEQUE_DEPTH = wstd_pkg::DEQUE_DEPTH_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire  [3:0]           i_cfg_wdata,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire  wstd_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output wstd_pkg::t_out_item  o_out_item
);
    import wstd_pkg::*;

    localparam int WW  = $clog2(WORKER_CNT);
    localparam int AW  = $clog2(WORKER_CNT + 1);
    localparam int PW  = $clog2(DEQUE_DEPTH) + 1;
    localparam int RAW = WW + $clog2(DEQUE_DEPTH);

    logic [3:0]      r_active;
    logic [AW-1:0]   act;
    logic            r_out_vld;
    t_out_item       r_out_item;

    logic            res_vld;
    logic            res_take;
    t_out_item       res;

    logic [WW-1:0]   ptr_rd_addr;
    logic [PW-1:0]   ptr_rd_head;
    logic [PW-1:0]   ptr_rd_tail;
    logic            ptr_we;
    logic [WW-1:0]   ptr_wr_addr;
    logic [PW-1:0]   ptr_wr_head;
    logic [PW-1:0]   ptr_wr_tail;
    logic            ram_we;
    logic [RAW-1:0]  ram_wr_addr;
    logic [31:0]     ram_wr_data;
    logic            ram_rd_en;
    logic [RAW-1:0]  ram_rd_addr;
    logic [31:0]     ram_rd_data;

    // Active worker count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
        end else if (i_cfg_we) begin
            r_active <= i_cfg_wdata;
        end
    end

    // Clamp to 1..WORKER_CNT
    always_comb begin
        if (r_active == 4'd0) begin
            act = AW'(1);
        end else if (32'(r_active) > 32'(WORKER_CNT)) begin
            act = AW'(WORKER_CNT);
        end else begin
            act = AW'(r_active);
        end
    end

    // Output register
    assign res_take = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_take) begin
            r_out_vld <= res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take && res_vld) begin
            r_out_item <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

    wstd_ptr_table #(
        .WORKER_CNT  (WORKER_CNT),
        .DEQUE_DEPTH (DEQUE_DEPTH)
    ) u_ptr_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (ptr_rd_addr),
        .o_rd_head (ptr_rd_head),
        .o_rd_tail (ptr_rd_tail),
        .i_we      (ptr_we),
        .i_wr_addr (ptr_wr_addr),
        .i_wr_head (ptr_wr_head),
        .i_wr_tail (ptr_wr_tail)
    );

    wstd_task_ram #(
        .WORKER_CNT  (WORKER_CNT),
        .DEQUE_DEPTH (DEQUE_DEPTH)
    ) u_task_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    wstd_seq #(
        .WORKER_CNT  (WORKER_CNT),
        .DEQUE_DEPTH (DEQUE_DEPTH)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_act         (act),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_item     (i_in_item),
        .o_res_vld     (res_vld),
        .i_res_take    (res_take),
        .o_res         (res),
        .o_ptr_rd_addr (ptr_rd_addr),
        .i_ptr_rd_head (ptr_rd_head),
        .i_ptr_rd_tail (ptr_rd_tail),
        .o_ptr_we      (ptr_we),
        .o_ptr_wr_addr (ptr_wr_addr),
        .o_ptr_wr_head (ptr_wr_head),
        .o_ptr_wr_tail (ptr_wr_tail),
        .o_ram_we      (ram_we),
        .o_ram_wr_addr (ram_wr_addr),
        .o_ram_wr_data (ram_wr_data),
        .o_ram_rd_en   (ram_rd_en),
        .o_ram_rd_addr (ram_rd_addr),
        .i_ram_rd_data (ram_rd_data)
    );

endmodule

`default_nettype wire
